/* rtl/cjt_pkg.sv */
// cjt_pkg: shared types, constants and helpers of the cubic joint trajectory generator
// used by cjt_div, cjt_mac and cubic_joint_trajectory_generator
package cjt_pkg;

  localparam int JointCount   = 3;
  localparam int JointW       = 2;
  localparam int CoefPerJoint = 4;
  localparam int DivW         = 128;
  localparam int DivCntW      = $clog2(DivW);
  localparam int MagW         = 36;
  localparam int TermCount    = 5;
  localparam int TermIdxW     = 3;
  localparam int StepCount    = 6;
  localparam int StepIdxW     = 3;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_DUR   = 2'd1,
    ST_NOT_LOADED = 2'd2,
    ST_SAT        = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LTERM,
    S_LDIV,
    S_LWR,
    S_ESCALE,
    S_EMAC,
    S_EWAIT,
    S_EQ16,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    M_IDLE,
    M_LO,
    M_HI,
    M_SUM,
    M_FIN
  } mac_phase_e;

  typedef struct packed {
    logic              start;
    logic [DivW-1:0]   dividend;
    logic [31:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DivW-1:0]   quot;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
    logic [31:0] t;
    logic [63:0] c;
  } mac_req_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [63:0] y;
  } mac_rsp_t;

  typedef struct packed {
    logic [6:0] shift;
    logic [1:0] ndiv;
    logic       to_c3;
    logic       sub;
  } term_t;

  // c2 = A - B - C, c3 = -D + E
  function automatic term_t term_info(logic [TermIdxW-1:0] idx);
    term_t r;
    case (idx)
      3'd0:    r = '{shift: 7'd48, ndiv: 2'd2, to_c3: 1'b0, sub: 1'b0};
      3'd1:    r = '{shift: 7'd32, ndiv: 2'd1, to_c3: 1'b0, sub: 1'b1};
      3'd2:    r = '{shift: 7'd32, ndiv: 2'd1, to_c3: 1'b0, sub: 1'b1};
      3'd3:    r = '{shift: 7'd64, ndiv: 2'd3, to_c3: 1'b1, sub: 1'b1};
      3'd4:    r = '{shift: 7'd48, ndiv: 2'd2, to_c3: 1'b1, sub: 1'b0};
      default: r = '{shift: 7'd0,  ndiv: 2'd1, to_c3: 1'b0, sub: 1'b0};
    endcase
    return r;
  endfunction

  function automatic logic ovf64(logic [127:0] a);
    return !((&a[127:63]) || !(|a[127:63]));
  endfunction

  function automatic logic [63:0] clamp64(logic [127:0] a);
    logic [63:0] r;
    if (ovf64(a)) begin
      r = a[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      r = a[63:0];
    end
    return r;
  endfunction

endpackage

/* rtl/cjt_div.sv */
// cjt_div: iterative restoring divider, 128-bit dividend by 32-bit divisor, one bit a cycle
// depends on cjt_pkg
module cjt_div import cjt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    sh_q, sh_d;
  logic [31:0]        rem_q, rem_d;
  logic [31:0]        dvs_q, dvs_d;
  logic [32:0]        part;
  logic [32:0]        diff;
  logic               ge;

  assign part = {rem_q, sh_q[DivW-1]};
  assign diff = part - {1'b0, dvs_q};
  assign ge   = part >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // quotient bits shift in where dividend bits shift out
      sh_d  = {sh_q[DivW-2:0], ge};
      rem_d = ge ? diff[31:0] : part[31:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q;

endmodule

/* rtl/cjt_mac.sv */
// cjt_mac: multi-cycle horner step sat64(c + trunc(x*t/2^16)) on one shared 32x32 multiplier
// depends on cjt_pkg
module cjt_mac import cjt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_req_t req_i,
  output mac_rsp_t rsp_o
);

  mac_phase_e  phase_q, phase_d;
  logic        neg_q;
  logic [63:0] mag_q;
  logic [31:0] t_q;
  logic [63:0] c_q;
  logic [63:0] lo_q, hi_q;
  logic [79:0] w_q;
  logic [63:0] y_q;
  logic        sat_q;
  logic        done_q;
  logic [31:0] op_a;
  logic [63:0] prod;
  logic [95:0] w96;
  logic [127:0] sw;
  logic [127:0] sum;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      M_IDLE:  if (req_i.start) phase_d = M_LO;
      M_LO:    phase_d = M_HI;
      M_HI:    phase_d = M_SUM;
      M_SUM:   phase_d = M_FIN;
      M_FIN:   phase_d = M_IDLE;
      default: phase_d = M_IDLE;
    endcase
  end

  assign op_a = (phase_q == M_LO) ? mag_q[31:0] : mag_q[63:32];
  assign prod = op_a * t_q;
  assign w96  = {32'd0, lo_q} + {hi_q, 32'd0};
  assign sw   = neg_q ? (~{48'd0, w_q} + 128'd1) : {48'd0, w_q};
  assign sum  = sw + {{64{c_q[63]}}, c_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == M_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == M_IDLE && req_i.start) begin
      neg_q <= req_i.x[63];
      mag_q <= req_i.x[63] ? (~req_i.x + 64'd1) : req_i.x;
      t_q   <= req_i.t;
      c_q   <= req_i.c;
    end
    if (phase_q == M_LO) lo_q <= prod;
    if (phase_q == M_HI) hi_q <= prod;
    if (phase_q == M_SUM) w_q <= w96[95:16];
    if (phase_q == M_FIN) begin
      y_q   <= clamp64(sum);
      sat_q <= ovf64(sum);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.y    = y_q;

endmodule

/* rtl/cubic_joint_trajectory_generator.sv */
// channel | handshake            | payload
// in      | in_valid_i/in_stall_o | cmd, joint, angles, velocities, duration, sample_time
// out     | out_valid_o/out_stall_i | position, velocity, acceleration, status
// load: five quotient terms, nine passes of the shared 128-bit divider
// evaluate: six horner steps on the shared multiplier
// rejected items (bad joint, zero duration, unloaded joint) go straight to the done state
// one item at a time; the result register frees the core while a result waits, until the next item is done
// reset clears the loaded flags; coefficients are undefined until their joint is loaded
module cubic_joint_trajectory_generator import cjt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [0:0]  cmd_i,
  input  logic [1:0]  joint_i,
  input  logic signed [31:0] start_angle_i,
  input  logic signed [31:0] goal_angle_i,
  input  logic signed [31:0] start_velocity_i,
  input  logic signed [31:0] goal_velocity_i,
  input  logic [31:0] duration_i,
  input  logic [31:0] sample_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] position_o,
  output logic signed [31:0] velocity_o,
  output logic signed [31:0] acceleration_o,
  output logic [1:0]  status_o
);

  state_e state_q, state_d;

  logic [0:0]  cmd_q;
  logic [JointW-1:0] joint_q;
  logic [31:0] qs_q, qg_q, vs_q, vg_q, dur_q, t_q;

  logic [JointCount-1:0] flags_q, flags_d;
  logic [63:0] coef_q [JointCount][CoefPerJoint];

  logic [TermIdxW-1:0] term_q, term_d;
  logic [1:0]  divs_left_q, divs_left_d;
  logic        term_neg_q, term_neg_d;
  logic [127:0] acc2_q, acc2_d, acc3_q, acc3_d;
  logic        sat_q, sat_d;

  logic [63:0] two_c2_q, two_c2_d, x3_q, x3_d, x6_q, x6_d;
  logic [63:0] p_q, p_d, v_q, v_d, a_q, a_d;
  logic [StepIdxW-1:0] step_q, step_d;

  logic [31:0] res_pos_q, res_pos_d, res_vel_q, res_vel_d, res_acc_q, res_acc_d;
  status_e     res_st_q, res_st_d;

  logic        out_valid_q;
  logic [31:0] pos_q, vel_q, acc_q;
  status_e     st_q;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mac_req_t mac_req;
  mac_rsp_t mac_rsp;

  logic        in_xfer;
  logic        out_free;
  logic        joint_ok;
  term_t       tinfo;
  logic [MagW-1:0] qs36, qg36, vs36, vg36, d36, tval, tmag;
  logic [127:0] tdividend;
  logic [127:0] tsigned;
  logic [65:0]  c2x2;
  logic [66:0]  c3x3, c3x6;
  logic [63:0]  c0w, c1w;
  logic [32:0]  qp, qv, qa;

  cjt_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  cjt_mac u_mac (.clk_i, .rst_ni, .req_i(mac_req), .rsp_o(mac_rsp));

  function automatic logic [32:0] to_q16(logic [63:0] x);
    logic        neg;
    logic [63:0] mag;
    logic [47:0] m;
    logic [32:0] r;
    neg = x[63];
    mag = neg ? (~x + 64'd1) : x;
    m   = mag[63:16];
    if (!neg && m > 48'h7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (neg && m > 48'h8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, neg ? (~m[31:0] + 32'd1) : m[31:0]};
    end
    return r;
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign joint_ok   = joint_i < JointW'(JointCount);

  // load term operands, 36-bit signed
  assign qs36  = {{4{qs_q[31]}}, qs_q};
  assign qg36  = {{4{qg_q[31]}}, qg_q};
  assign vs36  = {{4{vs_q[31]}}, vs_q};
  assign vg36  = {{4{vg_q[31]}}, vg_q};
  assign d36   = qg36 - qs36;
  assign tinfo = term_info(term_q);

  always_comb begin
    case (term_q)
      3'd0:    tval = d36 + {d36[MagW-2:0], 1'b0};
      3'd1:    tval = {vs36[MagW-2:0], 1'b0};
      3'd2:    tval = vg36;
      3'd3:    tval = {d36[MagW-2:0], 1'b0};
      3'd4:    tval = vs36 + vg36;
      default: tval = '0;
    endcase
  end

  assign tmag      = tval[MagW-1] ? (~tval + MagW'(1)) : tval;
  assign tdividend = {{(DivW-MagW){1'b0}}, tmag} << tinfo.shift;
  assign tsigned   = (term_neg_q ^ tinfo.sub) ? (~div_rsp.quot + 128'd1) : div_rsp.quot;

  assign c0w = {{16{qs_q[31]}}, qs_q, 16'd0};
  assign c1w = {{16{vs_q[31]}}, vs_q, 16'd0};

  // 2*c2, 3*c3 and 6*c3 before saturation
  assign c2x2 = {{2{coef_q[joint_q][2][63]}}, coef_q[joint_q][2]} << 1;
  assign c3x3 = ({{3{coef_q[joint_q][3][63]}}, coef_q[joint_q][3]} << 1)
              + {{3{coef_q[joint_q][3][63]}}, coef_q[joint_q][3]};
  assign c3x6 = c3x3 << 1;

  assign qp = to_q16(p_q);
  assign qv = to_q16(v_q);
  assign qa = to_q16(a_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (!joint_ok) begin
            state_d = S_DONE;
          end else if (cmd_i == CMD_LOAD) begin
            state_d = (duration_i == 32'd0) ? S_DONE : S_LTERM;
          end else begin
            state_d = flags_q[joint_i] ? S_ESCALE : S_DONE;
          end
        end
      end
      S_LTERM: state_d = S_LDIV;
      S_LDIV: begin
        if (div_rsp.done && divs_left_q == 2'd1) begin
          state_d = (term_q == TermIdxW'(TermCount - 1)) ? S_LWR : S_LTERM;
        end
      end
      S_LWR:    state_d = S_DONE;
      S_ESCALE: state_d = S_EMAC;
      S_EMAC:   state_d = S_EWAIT;
      S_EWAIT: begin
        if (mac_rsp.done) begin
          state_d = (step_q == StepIdxW'(StepCount - 1)) ? S_EQ16 : S_EMAC;
        end
      end
      S_EQ16: state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and unit requests
  always_comb begin
    flags_d     = flags_q;
    term_d      = term_q;
    divs_left_d = divs_left_q;
    term_neg_d  = term_neg_q;
    acc2_d      = acc2_q;
    acc3_d      = acc3_q;
    sat_d       = sat_q;
    two_c2_d    = two_c2_q;
    x3_d        = x3_q;
    x6_d        = x6_q;
    p_d         = p_q;
    v_d         = v_q;
    a_d         = a_q;
    step_d      = step_q;
    res_pos_d   = res_pos_q;
    res_vel_d   = res_vel_q;
    res_acc_d   = res_acc_q;
    res_st_d    = res_st_q;
    div_req     = '{start: 1'b0, dividend: tdividend, divisor: dur_q};
    mac_req     = '{start: 1'b0, x: coef_q[joint_q][3], t: t_q, c: coef_q[joint_q][2]};
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          term_d    = '0;
          step_d    = '0;
          acc2_d    = '0;
          acc3_d    = '0;
          sat_d     = 1'b0;
          res_pos_d = '0;
          res_vel_d = '0;
          res_acc_d = '0;
          if (!joint_ok) begin
            res_st_d = ST_NOT_LOADED;
          end else if (cmd_i == CMD_LOAD) begin
            res_st_d = (duration_i == 32'd0) ? ST_ZERO_DUR : ST_OK;
          end else begin
            res_st_d = flags_q[joint_i] ? ST_OK : ST_NOT_LOADED;
          end
        end
      end
      S_LTERM: begin
        div_req.start = 1'b1;
        divs_left_d   = tinfo.ndiv;
        term_neg_d    = tval[MagW-1];
      end
      S_LDIV: begin
        if (div_rsp.done) begin
          if (divs_left_q != 2'd1) begin
            // divide the quotient by the duration again
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quot;
            divs_left_d      = divs_left_q - 2'd1;
          end else begin
            if (tinfo.to_c3) acc3_d = acc3_q + tsigned;
            else             acc2_d = acc2_q + tsigned;
            term_d = term_q + 1'b1;
          end
        end
      end
      S_LWR: begin
        flags_d[joint_q] = 1'b1;
        if (ovf64(acc2_q) || ovf64(acc3_q)) res_st_d = ST_SAT;
      end
      S_ESCALE: begin
        two_c2_d = clamp64({{62{c2x2[65]}}, c2x2});
        x3_d     = clamp64({{61{c3x3[66]}}, c3x3});
        x6_d     = clamp64({{61{c3x6[66]}}, c3x6});
        sat_d    = ovf64({{62{c2x2[65]}}, c2x2}) || ovf64({{61{c3x3[66]}}, c3x3})
                || ovf64({{61{c3x6[66]}}, c3x6});
      end
      S_EMAC: begin
        mac_req.start = 1'b1;
        case (step_q)
          3'd0:    begin mac_req.x = coef_q[joint_q][3]; mac_req.c = coef_q[joint_q][2]; end
          3'd1:    begin mac_req.x = p_q;  mac_req.c = coef_q[joint_q][1]; end
          3'd2:    begin mac_req.x = p_q;  mac_req.c = coef_q[joint_q][0]; end
          3'd3:    begin mac_req.x = x3_q; mac_req.c = two_c2_q; end
          3'd4:    begin mac_req.x = v_q;  mac_req.c = coef_q[joint_q][1]; end
          3'd5:    begin mac_req.x = x6_q; mac_req.c = two_c2_q; end
          default: begin mac_req.x = x6_q; mac_req.c = two_c2_q; end
        endcase
      end
      S_EWAIT: begin
        if (mac_rsp.done) begin
          sat_d  = sat_q || mac_rsp.sat;
          step_d = step_q + 1'b1;
          case (step_q)
            3'd0, 3'd1, 3'd2: p_d = mac_rsp.y;
            3'd3, 3'd4:       v_d = mac_rsp.y;
            default:          a_d = mac_rsp.y;
          endcase
        end
      end
      S_EQ16: begin
        res_pos_d = qp[31:0];
        res_vel_d = qv[31:0];
        res_acc_d = qa[31:0];
        res_st_d  = (sat_q || qp[32] || qv[32] || qa[32]) ? ST_SAT : ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flags_q <= flags_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= cmd_i;
      joint_q <= joint_i;
      qs_q    <= start_angle_i;
      qg_q    <= goal_angle_i;
      vs_q    <= start_velocity_i;
      vg_q    <= goal_velocity_i;
      dur_q   <= duration_i;
      t_q     <= sample_time_i;
    end
    if (state_q == S_LWR) begin
      coef_q[joint_q][0] <= c0w;
      coef_q[joint_q][1] <= c1w;
      coef_q[joint_q][2] <= clamp64(acc2_q);
      coef_q[joint_q][3] <= clamp64(acc3_q);
    end
    term_q      <= term_d;
    divs_left_q <= divs_left_d;
    term_neg_q  <= term_neg_d;
    acc2_q      <= acc2_d;
    acc3_q      <= acc3_d;
    sat_q       <= sat_d;
    two_c2_q    <= two_c2_d;
    x3_q        <= x3_d;
    x6_q        <= x6_d;
    p_q         <= p_d;
    v_q         <= v_d;
    a_q         <= a_d;
    step_q      <= step_d;
    res_pos_q   <= res_pos_d;
    res_vel_q   <= res_vel_d;
    res_acc_q   <= res_acc_d;
    res_st_q    <= res_st_d;
    if (state_q == S_DONE && out_free) begin
      pos_q <= res_pos_q;
      vel_q <= res_vel_q;
      acc_q <= res_acc_q;
      st_q  <= res_st_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_o     = pos_q;
  assign velocity_o     = vel_q;
  assign acceleration_o = acc_q;
  assign status_o       = st_q;

  // evaluate uses the command captured at transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ESCALE) |-> (cmd_q == CMD_EVAL))
    else $error("evaluate sequence started for a load item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LWR) |=> flags_q[$past(joint_q)])
    else $error("joint not marked loaded after coefficient write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_LDIV))
    else $error("divider finished outside the load sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_rsp.done |-> (state_q == S_EWAIT))
    else $error("horner step finished outside the evaluate sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result presented without a finished item");

endmodule
